// ===== sv/dc_motor_euler_step_defines.svh =====
// Assertion macros shared by the motor model RTL.
// Depends on nothing; the including module must provide clk and rst_n.
`ifndef DC_MOTOR_EULER_STEP_DEFINES_SVH
`define DC_MOTOR_EULER_STEP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DCM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define DCM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/dcme_pkg.sv =====
// Types, register map, microcode table and saturation helper for the motor model.
// Used by dc_motor_euler_step; depends on nothing.
package dcme_pkg;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef enum logic [2:0] {
    G_NONE,
    G_V2C,
    G_DECAY,
    G_BEMF,
    G_TORQUE,
    G_FRIC,
    G_STEP
  } gain_sel_t;

  typedef enum logic [1:0] {
    OP_VOLT,
    OP_CUR,
    OP_SPD,
    OP_ANG
  } opnd_sel_t;

  typedef enum logic [1:0] {
    ACC_NOP,
    ACC_LOAD,
    ACC_SUB
  } acc_op_t;

  typedef enum logic [1:0] {
    WB_NONE,
    WB_CUR,
    WB_SPD,
    WB_COMMIT
  } wb_sel_t;

  typedef struct packed {
    gain_sel_t gsel;
    opnd_sel_t msel;
    acc_op_t   acc_op;
    opnd_sel_t base_sel;
    wb_sel_t   wb;
    logic      loop_end;
  } ctl_t;

  localparam int UCODE_LEN = 8;
  localparam int PC_W = $clog2(UCODE_LEN);

  localparam logic [2:0] REG_V2C    = 3'd0;
  localparam logic [2:0] REG_DECAY  = 3'd1;
  localparam logic [2:0] REG_BEMF   = 3'd2;
  localparam logic [2:0] REG_TORQUE = 3'd3;
  localparam logic [2:0] REG_FRIC   = 3'd4;
  localparam logic [2:0] REG_STEP   = 3'd5;
  localparam logic [2:0] REG_LOW    = 3'd6;
  localparam logic [2:0] REG_HIGH   = 3'd7;

  // Each step multiplies into the product register while the accumulator
  // consumes the product of the step before.
  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t c;
    c = '{G_NONE, OP_VOLT, ACC_NOP, OP_VOLT, WB_NONE, 1'b0};
    case (pc)
      3'd0: c = '{G_V2C,    OP_VOLT, ACC_NOP,  OP_VOLT, WB_NONE,   1'b0};
      3'd1: c = '{G_DECAY,  OP_CUR,  ACC_LOAD, OP_CUR,  WB_NONE,   1'b0};
      3'd2: c = '{G_BEMF,   OP_SPD,  ACC_SUB,  OP_CUR,  WB_NONE,   1'b0};
      3'd3: c = '{G_TORQUE, OP_CUR,  ACC_SUB,  OP_CUR,  WB_NONE,   1'b0};
      3'd4: c = '{G_FRIC,   OP_SPD,  ACC_LOAD, OP_SPD,  WB_CUR,    1'b0};
      3'd5: c = '{G_STEP,   OP_SPD,  ACC_SUB,  OP_SPD,  WB_NONE,   1'b0};
      3'd6: c = '{G_NONE,   OP_VOLT, ACC_LOAD, OP_ANG,  WB_SPD,    1'b0};
      3'd7: c = '{G_NONE,   OP_VOLT, ACC_NOP,  OP_VOLT, WB_COMMIT, 1'b1};
      default: c = '{G_NONE, OP_VOLT, ACC_NOP, OP_VOLT, WB_NONE, 1'b0};
    endcase
    return c;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    r = v[31:0];
    if (v > 35'sd2147483647) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh8000_0000;
    end
    return r;
  endfunction

endpackage

// ===== sv/dc_motor_euler_step.sv =====
// Channel | Kind          | Payload (low bit up)
// in_     | stream slave  | drive_voltage[31:0]
// out_    | stream master | motor_current, rotor_speed, rotor_angle, hit_limit, zero pad
// cfg_    | APB slave     | eight 32-bit registers at byte addresses 0 to 28
// Each word runs SUBSTEPS substeps; each substep runs the microcode program, which uses
// the shared multiplier six times.
// A new word is taken the cycle after the previous one has finished its last substep,
// so no new word is accepted while one is in progress.
// The result sits in an output register; the last step waits only if that register
// is still full. Reset is synchronous and clears the control and model state and gains.
`include "dc_motor_euler_step_defines.svh"

module dc_motor_euler_step
  import dcme_pkg::*;
#(
  parameter int SUBSTEPS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // drive_voltage
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // motor_current, rotor_speed, rotor_angle, hit_limit, pad
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [4:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int SUB_W = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;
  localparam logic [SUB_W-1:0] SUB_LAST = SUB_W'(SUBSTEPS - 1);

  logic [31:0] gv2c_r, gdecay_r, gbemf_r, gtorque_r, gfric_r, gstep_r;
  logic signed [31:0] lo_r, hi_r;

  state_t state_r, state_nxt;
  logic [PC_W-1:0]  pc_r;
  logic [SUB_W-1:0] sub_r;
  logic signed [31:0] volt_r, cur_r, spd_r, ang_r, ncur_r, nspd_r, prod_r;
  logic signed [34:0] acc_r, acc_nxt;
  logic hit_r, out_valid_r;
  logic [103:0] out_data_r;

  ctl_t ctl;
  logic cfg_wr, accept, last_sub, stall, run_en, finish;
  logic [31:0] gain;
  logic signed [31:0] mopnd, base, ang_sat, ang_fin, spd_fin;
  logic signed [64:0] mul_full;
  logic clamp, hit_nxt;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gv2c_r    <= '0;
      gdecay_r  <= '0;
      gbemf_r   <= '0;
      gtorque_r <= '0;
      gfric_r   <= '0;
      gstep_r   <= '0;
      lo_r      <= 32'sh8000_0000;
      hi_r      <= 32'sh7FFF_FFFF;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        REG_V2C:    gv2c_r    <= cfg_pwdata;
        REG_DECAY:  gdecay_r  <= cfg_pwdata;
        REG_BEMF:   gbemf_r   <= cfg_pwdata;
        REG_TORQUE: gtorque_r <= cfg_pwdata;
        REG_FRIC:   gfric_r   <= cfg_pwdata;
        REG_STEP:   gstep_r   <= cfg_pwdata;
        REG_LOW:    lo_r      <= cfg_pwdata;
        REG_HIGH:   hi_r      <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      REG_V2C:    cfg_prdata = gv2c_r;
      REG_DECAY:  cfg_prdata = gdecay_r;
      REG_BEMF:   cfg_prdata = gbemf_r;
      REG_TORQUE: cfg_prdata = gtorque_r;
      REG_FRIC:   cfg_prdata = gfric_r;
      REG_STEP:   cfg_prdata = gstep_r;
      REG_LOW:    cfg_prdata = lo_r;
      REG_HIGH:   cfg_prdata = hi_r;
      default:    cfg_prdata = '0;
    endcase
  end

  // Sequencer control.
  assign ctl      = ucode(pc_r);
  assign accept   = in_tvalid & in_tready;
  assign last_sub = (sub_r == SUB_LAST);
  assign stall    = ctl.loop_end & last_sub & out_valid_r & ~out_tready;
  assign run_en   = (state_r == ST_RUN) & ~stall;
  assign finish   = run_en & ctl.loop_end & last_sub;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RUN;
      ST_RUN:  if (finish) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    case (state_r)
      ST_IDLE: in_tready = 1'b1;
      default: in_tready = 1'b0;
    endcase
  end

  // Datapath.
  always_comb begin
    case (ctl.gsel)
      G_V2C:    gain = gv2c_r;
      G_DECAY:  gain = gdecay_r;
      G_BEMF:   gain = gbemf_r;
      G_TORQUE: gain = gtorque_r;
      G_FRIC:   gain = gfric_r;
      G_STEP:   gain = gstep_r;
      default:  gain = '0;
    endcase
  end

  always_comb begin
    case (ctl.msel)
      OP_CUR:  mopnd = cur_r;
      OP_SPD:  mopnd = spd_r;
      OP_ANG:  mopnd = ang_r;
      default: mopnd = volt_r;
    endcase
  end

  always_comb begin
    case (ctl.base_sel)
      OP_CUR:  base = cur_r;
      OP_SPD:  base = spd_r;
      OP_ANG:  base = ang_r;
      default: base = volt_r;
    endcase
  end

  // The arithmetic shift of the exact product floors toward minus infinity.
  assign mul_full = mopnd * $signed({1'b0, gain});

  always_comb begin
    case (ctl.acc_op)
      ACC_LOAD: acc_nxt = 35'(base) + 35'(prod_r);
      ACC_SUB:  acc_nxt = acc_r - 35'(prod_r);
      default:  acc_nxt = acc_r;
    endcase
  end

  // Angle clamp; the low limit is tested first.
  always_comb begin
    ang_sat = sat32(acc_r);
    ang_fin = ang_sat;
    spd_fin = nspd_r;
    clamp   = 1'b0;
    if (ang_sat < lo_r) begin
      ang_fin = lo_r;
      spd_fin = '0;
      clamp   = 1'b1;
    end else if (ang_sat > hi_r) begin
      ang_fin = hi_r;
      spd_fin = '0;
      clamp   = 1'b1;
    end
  end

  assign hit_nxt = hit_r | clamp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
      sub_r   <= '0;
      hit_r   <= 1'b0;
      cur_r   <= '0;
      spd_r   <= '0;
      ang_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        pc_r  <= '0;
        sub_r <= '0;
        hit_r <= 1'b0;
      end else if (run_en) begin
        if (ctl.loop_end) begin
          pc_r  <= '0;
          sub_r <= last_sub ? '0 : sub_r + 1'b1;
        end else begin
          pc_r <= pc_r + 1'b1;
        end
        if (ctl.wb == WB_COMMIT) begin
          cur_r <= ncur_r;
          spd_r <= spd_fin;
          ang_r <= ang_fin;
          hit_r <= hit_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      volt_r <= in_tdata;
    end
    if (run_en) begin
      prod_r <= mul_full[63:32];
      acc_r  <= acc_nxt;
      if (ctl.wb == WB_CUR) begin
        ncur_r <= sat32(acc_r);
      end
      if (ctl.wb == WB_SPD) begin
        nspd_r <= sat32(acc_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= {7'd0, hit_nxt, ang_fin, spd_fin, ncur_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `DCM_ASSERT_NXT(a_start, accept, (state_r == ST_RUN) && (pc_r == '0) && !hit_r, "bad start")
  `DCM_ASSERT_IMP(a_idle_clean, state_r == ST_IDLE, (pc_r == '0) && (sub_r == '0), "idle dirty")
  `DCM_ASSERT_NXT(a_finish_out, finish, out_valid_r && (state_r == ST_IDLE), "result lost")
  `DCM_ASSERT_NXT(a_clamp, run_en && (ctl.wb == WB_COMMIT) && (lo_r <= hi_r),
    (ang_r >= lo_r) && (ang_r <= hi_r), "angle out of limits")

endmodule

// ===== dv/dc_motor_euler_step_tb.sv =====
// Testbench for dc_motor_euler_step: programs the motor gains and angle limits over APB,
// streams drive-voltage words in and checks every result word against a fixed-point
// model of the Euler substeps kept here. Depends on dcme_pkg and the RTL top level.
module dc_motor_euler_step_tb;
  import dcme_pkg::*;

  localparam int SUBSTEPS        = 4;
  localparam int STEP_CYCLES     = 8 * SUBSTEPS;
  localparam int QUIET_LIMIT     = 2000;
  localparam int RANDOM_PHASES   = 14;
  localparam int WORDS_PER_PHASE = 125;

  localparam logic [31:0] Q_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN     = 32'h8000_0000;
  localparam logic [31:0] Q_ONE     = 32'h0001_0000;
  localparam logic [31:0] GAIN_FULL = 32'hFFFF_FFFF;

  typedef struct {
    logic [31:0] current;
    logic [31:0] speed;
    logic [31:0] angle;
    logic        hit;
  } motor_result_t;

  logic         clk         = 1'b0;
  logic         rst_n       = 1'b0;
  logic         in_tvalid   = 1'b0;
  logic         in_tready;
  logic [31:0]  in_tdata    = '0;  // drive_voltage
  logic         out_tvalid;
  logic         out_tready  = 1'b0;
  logic [103:0] out_tdata;         // motor_current, rotor_speed, rotor_angle, hit_limit, pad
  logic         cfg_psel    = 1'b0;
  logic         cfg_penable = 1'b0;
  logic         cfg_pwrite  = 1'b0;
  logic [4:0]   cfg_paddr   = '0;
  logic [31:0]  cfg_pwdata  = '0;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  logic [31:0]        motor_regs [8];
  logic signed [31:0] current_now = '0;
  logic signed [31:0] speed_now   = '0;
  logic signed [31:0] angle_now   = '0;
  motor_result_t      expected_results [$];
  logic               steady_flow = 1'b0;

  int errors          = 0;
  int words_sent      = 0;
  int results_checked = 0;
  int settings_loaded = 0;
  int limit_hits      = 0;
  int quiet_cycles    = 0;

  dc_motor_euler_step #(
    .SUBSTEPS(SUBSTEPS)
  ) dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  // Signed Q16.16 value times unsigned Q0.32 gain, rounded toward minus infinity.
  function automatic longint gain_product(logic [31:0] gain, logic signed [31:0] x);
    longint p;
    p = longint'(x) * longint'({32'd0, gain});
    return p >>> 32;
  endfunction

  function automatic logic signed [31:0] clamp_q16(longint v);
    if (v > 64'sd2147483647) return Q_MAX;
    if (v < -64'sd2147483648) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic motor_result_t run_macro_step(logic signed [31:0] volt);
    motor_result_t      r;
    logic signed [31:0] lo, hi, ni, no, na;
    int                 n;
    r.hit = 1'b0;
    lo = motor_regs[REG_LOW];
    hi = motor_regs[REG_HIGH];
    for (n = 0; n < SUBSTEPS; n++) begin
      ni = clamp_q16(longint'(current_now) + gain_product(motor_regs[REG_V2C], volt)
                     - gain_product(motor_regs[REG_DECAY], current_now)
                     - gain_product(motor_regs[REG_BEMF], speed_now));
      no = clamp_q16(longint'(speed_now) + gain_product(motor_regs[REG_TORQUE], current_now)
                     - gain_product(motor_regs[REG_FRIC], speed_now));
      na = clamp_q16(longint'(angle_now) + gain_product(motor_regs[REG_STEP], speed_now));
      if (na < lo) begin
        na = lo;
        no = '0;
        r.hit = 1'b1;
      end else if (na > hi) begin
        na = hi;
        no = '0;
        r.hit = 1'b1;
      end
      current_now = ni;
      speed_now   = no;
      angle_now   = na;
    end
    r.current = current_now;
    r.speed   = speed_now;
    r.angle   = angle_now;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 40) $display("Mismatch on %s: got %h, expected %h", what, got, want);
  endtask

  // Drivers are entered and left just after a falling edge.
  task automatic send_voltage(logic [31:0] volt);
    motor_result_t res;
    if (!steady_flow && $urandom_range(0, 99) < 11) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, STEP_CYCLES + 4)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= volt;
    do @(posedge clk); while (!in_tready);
    res = run_macro_step(volt);
    if (res.hit) limit_hits++;
    expected_results.push_back(res);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic wait_until_idle();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_access(input logic is_write, input logic [2:0] idx,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= is_write;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    if (is_write) motor_regs[idx] = wdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    logic [31:0] unused;
    cfg_access(1'b1, idx, value, unused);
  endtask

  task automatic check_all_regs();
    logic [31:0] got;
    int          idx;
    for (idx = 0; idx < 8; idx++) begin
      cfg_access(1'b0, 3'(idx), '0, got);
      if (got !== motor_regs[idx])
        report_mismatch($sformatf("register %0d readback", idx), got, motor_regs[idx]);
    end
  endtask

  task automatic set_motor(logic [31:0] v2c, logic [31:0] decay, logic [31:0] bemf,
                           logic [31:0] torque, logic [31:0] fric, logic [31:0] step_len,
                           logic [31:0] low_lim, logic [31:0] high_lim);
    wait_until_idle();
    write_reg(REG_V2C, v2c);
    write_reg(REG_DECAY, decay);
    write_reg(REG_BEMF, bemf);
    write_reg(REG_TORQUE, torque);
    write_reg(REG_FRIC, fric);
    write_reg(REG_STEP, step_len);
    write_reg(REG_LOW, low_lim);
    write_reg(REG_HIGH, high_lim);
    settings_loaded++;
  endtask

  function automatic logic [31:0] low_gain(int bits);
    return $urandom() >> (32 - bits);
  endfunction

  function automatic logic [31:0] edge_gain();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return GAIN_FULL;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] edge_limit();
    case ($urandom_range(0, 3))
      0:       return Q_MIN;
      1:       return Q_MAX;
      2:       return '0;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_voltage(int span);
    case ($urandom_range(0, 9))
      0:       return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
      1, 2:    return $urandom();
      3:       return $urandom_range(0, 2) - 1;
      default: return $urandom_range(0, 2 * span) - span;
    endcase
  endfunction

  task automatic test_reset_values();
    check_all_regs();
    send_voltage(Q_MAX);
    send_voltage(Q_MIN);
    send_voltage('0);
    send_voltage(32'hFFFF_FFFF);
  endtask

  task automatic test_register_access();
    int idx;
    wait_until_idle();
    for (idx = 0; idx < 8; idx++) write_reg(3'(idx), $urandom());
    check_all_regs();
  endtask

  task automatic test_saturation();
    set_motor(GAIN_FULL, '0, '0, GAIN_FULL, '0, GAIN_FULL, Q_MIN, Q_MAX);
    repeat (3) send_voltage(Q_MAX);
    send_voltage('0);
    repeat (3) send_voltage(Q_MIN);
  endtask

  task automatic test_angle_limits();
    set_motor(32'h1000_0000, 32'h0800_0000, 32'h0100_0000, 32'h4000_0000,
              32'h0200_0000, 32'h2000_0000, -2 * Q_ONE, 2 * Q_ONE);
    repeat (3) send_voltage(32'h000C_0000);
    repeat (4) send_voltage(32'hFFF4_0000);
  endtask

  // With the low limit above the high one every angle ends up clamped to one of them.
  task automatic test_crossed_limits();
    set_motor(32'h1000_0000, GAIN_FULL, 32'h0100_0000, 32'h4000_0000,
              GAIN_FULL, 32'h2000_0000, Q_ONE, -Q_ONE);
    send_voltage('0);
    send_voltage(Q_ONE);
    send_voltage(-Q_ONE);
    send_voltage(Q_MAX);
    set_motor(32'h1000_0000, GAIN_FULL, 32'h0100_0000, 32'h4000_0000,
              GAIN_FULL, 32'h2000_0000, Q_MAX, Q_MIN);
    send_voltage(Q_MIN);
    send_voltage('0);
    send_voltage(Q_MAX);
  endtask

  task automatic test_random_operation();
    int          phase, k, span;
    logic [31:0] lim;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      span = 1 << $urandom_range(4, 21);
      case (phase % 4)
        0: begin
          lim = $urandom_range(Q_ONE, 200 * Q_ONE);
          set_motor(low_gain(28), low_gain(30), low_gain(26), low_gain(31), low_gain(28),
                    low_gain(30), -lim, lim);
        end
        1: begin
          set_motor($urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom());
          span = 1 << 30;
        end
        2: begin
          set_motor(edge_gain(), edge_gain(), edge_gain(), edge_gain(), edge_gain(),
                    edge_gain(), edge_limit(), edge_limit());
        end
        default: begin
          set_motor(low_gain(28), low_gain(30), low_gain(26), low_gain(31), low_gain(28),
                    low_gain(30), $urandom_range(0, 200 * Q_ONE) - 100 * Q_ONE,
                    $urandom_range(0, 200 * Q_ONE) - 100 * Q_ONE);
        end
      endcase
      steady_flow <= (phase == RANDOM_PHASES / 2);
      for (k = 0; k < WORDS_PER_PHASE; k++) send_voltage(pick_voltage(span));
    end
    steady_flow <= 1'b0;
  endtask

  always @(negedge clk) out_tready <= steady_flow || ($urandom_range(0, 99) >= 11);

  always @(posedge clk) begin
    motor_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing expected", out_tdata[31:0], '0);
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[31:0] !== want.current)
          report_mismatch($sformatf("word %0d motor_current", results_checked),
                          out_tdata[31:0], want.current);
        if (out_tdata[63:32] !== want.speed)
          report_mismatch($sformatf("word %0d rotor_speed", results_checked),
                          out_tdata[63:32], want.speed);
        if (out_tdata[95:64] !== want.angle)
          report_mismatch($sformatf("word %0d rotor_angle", results_checked),
                          out_tdata[95:64], want.angle);
        if (out_tdata[96] !== want.hit)
          report_mismatch($sformatf("word %0d hit_limit", results_checked),
                          {31'd0, out_tdata[96]}, {31'd0, want.hit});
        if (out_tdata[103:97] !== '0)
          report_mismatch($sformatf("word %0d padding", results_checked),
                          {25'd0, out_tdata[103:97]}, '0);
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_psel && cfg_penable && cfg_pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    motor_regs = '{'0, '0, '0, '0, '0, '0, Q_MIN, Q_MAX};
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_values();
    test_register_access();
    test_saturation();
    test_angle_limits();
    test_crossed_limits();
    test_random_operation();
    wait_until_idle();
    repeat (STEP_CYCLES + 8) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), '0);
    $display("Summary: %0d drive words under %0d gain and limit settings, %0d results checked.",
             words_sent, settings_loaded, results_checked);
    $display("Summary: %0d results carried an angle clamp, %0d mismatches counted.",
             limit_hits, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
